FILE: design/imhq_pkg.sv
// Shared types and constants for the indexed min-heap queue.
// No dependencies; imported by the top level.
package imhq_pkg;

  localparam int ID_W         = 10;
  localparam int FUNC_W       = 2;
  localparam int STATUS_W     = 2;
  localparam int SCORE_IN_W   = 32;
  localparam int DEF_CAPACITY = 1024;
  localparam int DEF_ID_COUNT = 1024;
  localparam int DEF_SCORE_BITS = 32;

  typedef enum logic [FUNC_W-1:0] {
    FN_INSERT = 2'd0,
    FN_POP    = 2'd1,
    FN_PEEK   = 2'd2,
    FN_REKEY  = 2'd3
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK       = 2'd0,
    STS_FULL     = 2'd1,
    STS_EMPTY    = 2'd2,
    STS_CONFLICT = 2'd3
  } status_e;

endpackage

FILE: design/imhq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Standalone; instanced by the top level for slot and id storage.
module imhq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write, then register the read word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/indexed_min_heap_queue.sv
// Indexed binary min-heap priority queue: sequencer over two RAMs.
// Depends on imhq_pkg and imhq_ram.
//
// Use: requests enter on in_valid_i/in_ready_o carrying func_i, item_id_i and
// new_score_i; each gives one result transaction on out_valid_o/out_ready_i
// with status_o, out_id_o, out_score_o and entry_count_o.
// One request is worked on at a time. A peek or a failed request goes from the
// lookup straight to the result; an insert climbs the heap, a pop descends it
// and a rekey climbs and then descends. The walks are bound by the single
// registered read port of the slot RAM: each level climbed costs one read, then
// a compare and a write back; each level descended costs a read of each child,
// then a compare and a write back.
// After reset the block runs a clearing pass over every entry of the id RAM
// with in_ready_o low, so that every id reads as absent.
// The result sits in an output register; when the receiver stalls, the next
// request is still accepted and worked, and its result waits inside until the
// output register is free.
module indexed_min_heap_queue #(
  parameter int CAPACITY   = imhq_pkg::DEF_CAPACITY,
  parameter int ID_COUNT   = imhq_pkg::DEF_ID_COUNT,
  parameter int SCORE_BITS = imhq_pkg::DEF_SCORE_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [imhq_pkg::FUNC_W-1:0]         func_i,
  input  logic [imhq_pkg::ID_W-1:0]           item_id_i,
  input  logic [imhq_pkg::SCORE_IN_W-1:0]     new_score_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [imhq_pkg::STATUS_W-1:0]       status_o,
  output logic [imhq_pkg::ID_W-1:0]           out_id_o,
  output logic [imhq_pkg::SCORE_IN_W-1:0]     out_score_o,
  output logic [$clog2(CAPACITY+1)-1:0]       entry_count_o
);
  import imhq_pkg::*;

  localparam int SLOT_W  = $clog2(CAPACITY);
  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int IDX_W   = $clog2(ID_COUNT);
  localparam int SLOT_DW = ID_W + SCORE_BITS;
  localparam int POS_DW  = SLOT_W + 1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_LOOKUP, S_POPLAST, S_UP, S_UPCMP,
    S_DOWN, S_DNL, S_DNR, S_DNCMP, S_PLACE, S_FIN
  } state_e;

  state_e                state_q, state_d;
  func_e                 func_q, func_d;
  logic [ID_W-1:0]       id_q, id_d;
  logic                  valid_id_q, valid_id_d;
  logic [ID_W-1:0]       cur_id_q, cur_id_d;
  logic [SCORE_BITS-1:0] score_q, score_d;
  logic [SLOT_W-1:0]     hole_q, hole_d;
  logic [SLOT_W-1:0]     best_idx_q, best_idx_d;
  logic [ID_W-1:0]       best_id_q, best_id_d;
  logic [SCORE_BITS-1:0] best_score_q, best_score_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [IDX_W-1:0]      clr_q, clr_d;
  status_e               res_status_q, res_status_d;
  logic [ID_W-1:0]       res_id_q, res_id_d;
  logic [SCORE_BITS-1:0] res_score_q, res_score_d;
  logic                  out_valid_q, out_valid_d;
  status_e               out_status_q, out_status_d;
  logic [ID_W-1:0]       out_id_q, out_id_d;
  logic [SCORE_BITS-1:0] out_score_q, out_score_d;
  logic [CNT_W-1:0]      out_count_q, out_count_d;

  logic                  slot_we;
  logic [SLOT_W-1:0]     slot_waddr, slot_raddr;
  logic [SLOT_DW-1:0]    slot_wdata, slot_rdata;
  logic                  pos_we;
  logic [IDX_W-1:0]      pos_waddr, pos_raddr;
  logic [POS_DW-1:0]     pos_wdata, pos_rdata;

  logic [ID_W-1:0]       rd_id;
  logic [SCORE_BITS-1:0] rd_score;
  logic                  rd_present;
  logic [SLOT_W-1:0]     rd_pos;
  logic [SLOT_W-1:0]     parent;
  logic [SLOT_W:0]       child_l, child_r, count_ext;

  imhq_ram #(.WIDTH(SLOT_DW), .DEPTH(CAPACITY)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_waddr),
    .wdata_i (slot_wdata),
    .raddr_i (slot_raddr),
    .rdata_o (slot_rdata)
  );

  imhq_ram #(.WIDTH(POS_DW), .DEPTH(ID_COUNT)) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (pos_we),
    .waddr_i (pos_waddr),
    .wdata_i (pos_wdata),
    .raddr_i (pos_raddr),
    .rdata_o (pos_rdata)
  );

  // Split read words and derive tree neighbours of the hole
  assign rd_id      = slot_rdata[SLOT_DW-1 -: ID_W];
  assign rd_score   = slot_rdata[SCORE_BITS-1:0];
  assign rd_present = pos_rdata[SLOT_W];
  assign rd_pos     = pos_rdata[SLOT_W-1:0];
  assign parent     = (hole_q - SLOT_W'(1)) >> 1;
  assign child_l    = {hole_q, 1'b1};
  assign child_r    = child_l + (SLOT_W + 1)'(1);
  assign count_ext  = (SLOT_W + 1)'(count_q);

  assign in_ready_o = (state_q == S_IDLE);

  // Sequence one request through read, compare and write-back steps
  always_comb begin
    state_d      = state_q;
    func_d       = func_q;
    id_d         = id_q;
    valid_id_d   = valid_id_q;
    cur_id_d     = cur_id_q;
    score_d      = score_q;
    hole_d       = hole_q;
    best_idx_d   = best_idx_q;
    best_id_d    = best_id_q;
    best_score_d = best_score_q;
    count_d      = count_q;
    clr_d        = clr_q;
    res_status_d = res_status_q;
    res_id_d     = res_id_q;
    res_score_d  = res_score_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_id_d     = out_id_q;
    out_score_d  = out_score_q;
    out_count_d  = out_count_q;
    slot_we      = 1'b0;
    slot_waddr   = hole_q;
    slot_wdata   = {cur_id_q, score_q};
    slot_raddr   = '0;
    pos_we       = 1'b0;
    pos_waddr    = IDX_W'(cur_id_q);
    pos_wdata    = {1'b1, hole_q};
    pos_raddr    = IDX_W'(item_id_i);

    // Drop the result once the receiver takes it
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_CLEAR: begin
        pos_we    = 1'b1;
        pos_waddr = clr_q;
        pos_wdata = '0;
        if (clr_q == IDX_W'(ID_COUNT - 1)) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + IDX_W'(1);
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          func_d     = func_e'(func_i);
          id_d       = item_id_i;
          valid_id_d = 32'(item_id_i) < 32'(ID_COUNT);
          score_d    = SCORE_BITS'(new_score_i);
          state_d    = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        res_status_d = STS_OK;
        res_id_d     = id_q;
        res_score_d  = '0;
        unique case (func_q)
          FN_INSERT: begin
            if (!valid_id_q || rd_present) begin
              res_status_d = STS_CONFLICT;
              state_d      = S_FIN;
            end else if (count_q == CNT_W'(CAPACITY)) begin
              res_status_d = STS_FULL;
              state_d      = S_FIN;
            end else begin
              cur_id_d = id_q;
              hole_d   = SLOT_W'(count_q);
              count_d  = count_q + CNT_W'(1);
              state_d  = S_UP;
            end
          end
          FN_POP, FN_PEEK: begin
            if (count_q == '0) begin
              res_status_d = STS_EMPTY;
              res_id_d     = '0;
              state_d      = S_FIN;
            end else begin
              res_id_d    = rd_id;
              res_score_d = rd_score;
              if (func_q == FN_PEEK) begin
                state_d = S_FIN;
              end else begin
                // Mark the root id absent and fetch the last slot
                pos_we    = 1'b1;
                pos_waddr = IDX_W'(rd_id);
                pos_wdata = '0;
                count_d   = count_q - CNT_W'(1);
                if (count_q == CNT_W'(1)) begin
                  state_d = S_FIN;
                end else begin
                  slot_raddr = SLOT_W'(count_q - CNT_W'(1));
                  state_d    = S_POPLAST;
                end
              end
            end
          end
          FN_REKEY: begin
            if (!valid_id_q || !rd_present || CNT_W'(rd_pos) >= count_q) begin
              res_status_d = STS_CONFLICT;
              state_d      = S_FIN;
            end else begin
              cur_id_d = id_q;
              hole_d   = rd_pos;
              state_d  = S_UP;
            end
          end
        endcase
      end
      S_POPLAST: begin
        cur_id_d = rd_id;
        score_d  = rd_score;
        hole_d   = '0;
        state_d  = S_DOWN;
      end
      S_UP: begin
        if (hole_q == '0) begin
          state_d = (func_q == FN_REKEY) ? S_DOWN : S_PLACE;
        end else begin
          slot_raddr = parent;
          state_d    = S_UPCMP;
        end
      end
      S_UPCMP: begin
        if (score_q < rd_score) begin
          // Move the parent down into the hole
          slot_we    = 1'b1;
          slot_wdata = slot_rdata;
          pos_we     = 1'b1;
          pos_waddr  = IDX_W'(rd_id);
          hole_d     = parent;
          state_d    = S_UP;
        end else begin
          state_d = (func_q == FN_REKEY) ? S_DOWN : S_PLACE;
        end
      end
      S_DOWN: begin
        if (child_l < count_ext) begin
          slot_raddr = child_l[SLOT_W-1:0];
          state_d    = S_DNL;
        end else begin
          state_d = S_PLACE;
        end
      end
      S_DNL: begin
        best_idx_d   = child_l[SLOT_W-1:0];
        best_id_d    = rd_id;
        best_score_d = rd_score;
        if (child_r < count_ext) begin
          slot_raddr = child_r[SLOT_W-1:0];
          state_d    = S_DNR;
        end else begin
          state_d = S_DNCMP;
        end
      end
      S_DNR: begin
        // Take the right child only when strictly smaller
        if (rd_score < best_score_q) begin
          best_idx_d   = child_r[SLOT_W-1:0];
          best_id_d    = rd_id;
          best_score_d = rd_score;
        end
        state_d = S_DNCMP;
      end
      S_DNCMP: begin
        if (best_score_q < score_q) begin
          // Move the smaller child up into the hole
          slot_we    = 1'b1;
          slot_wdata = {best_id_q, best_score_q};
          pos_we     = 1'b1;
          pos_waddr  = IDX_W'(best_id_q);
          hole_d     = best_idx_q;
          state_d    = S_DOWN;
        end else begin
          state_d = S_PLACE;
        end
      end
      S_PLACE: begin
        slot_we = 1'b1;
        pos_we  = 1'b1;
        state_d = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_id_d     = res_id_q;
          out_score_d  = res_score_q;
          out_count_d  = count_q;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Hold state, working registers and the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      func_q       <= FN_INSERT;
      id_q         <= '0;
      valid_id_q   <= 1'b0;
      cur_id_q     <= '0;
      score_q      <= '0;
      hole_q       <= '0;
      best_idx_q   <= '0;
      best_id_q    <= '0;
      best_score_q <= '0;
      count_q      <= '0;
      clr_q        <= '0;
      res_status_q <= STS_OK;
      res_id_q     <= '0;
      res_score_q  <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= STS_OK;
      out_id_q     <= '0;
      out_score_q  <= '0;
      out_count_q  <= '0;
    end else begin
      state_q      <= state_d;
      func_q       <= func_d;
      id_q         <= id_d;
      valid_id_q   <= valid_id_d;
      cur_id_q     <= cur_id_d;
      score_q      <= score_d;
      hole_q       <= hole_d;
      best_idx_q   <= best_idx_d;
      best_id_q    <= best_id_d;
      best_score_q <= best_score_d;
      count_q      <= count_d;
      clr_q        <= clr_d;
      res_status_q <= res_status_d;
      res_id_q     <= res_id_d;
      res_score_q  <= res_score_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
      out_id_q     <= out_id_d;
      out_score_q  <= out_score_d;
      out_count_q  <= out_count_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign out_id_o      = out_id_q;
  assign out_score_o   = SCORE_IN_W'(out_score_q);
  assign entry_count_o = out_count_q;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_accept_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_LOOKUP))
    else $error("accepted transaction did not start a lookup");

  a_upcmp_hole: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPCMP) |-> (hole_q != '0))
    else $error("sift up compare at the root");

  a_fin_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && out_valid_q && !out_ready_i) |=> (state_q == S_FIN))
    else $error("result overwrote a stalled transaction");
`endif

endmodule
